// ----- src/refcounted_slot_pool_unit_macros.svh -----
// Assertion macros for the reference-counted slot pool.
`ifndef REFCOUNTED_SLOT_POOL_UNIT_MACROS_SVH
`define REFCOUNTED_SLOT_POOL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RSPU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rspu check failed");
// next-cycle implication
`define RSPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rspu check failed");
`else
`define RSPU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RSPU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/rspu_pkg.sv -----
// Shared types and constants for the reference-counted slot pool.
package rspu_pkg;

   localparam int DEF_SLOT_COUNT = 16;
   localparam int DEF_COUNT_BITS = 8;

   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int PREV_W   = 8;
   localparam int POOL_W   = 5;

   // acquire search never goes past what the slot field can name
   localparam int SEARCH_MAX = 16;

   localparam logic [POOL_W-1:0] POOL_RESET = 5'd16;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

   // outcome of the free-slot search
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } search_result_type;

endpackage

// ----- src/refcounted_slot_pool_unit.sv -----
// Reference-counted slot pool: per-slot counts kept in a synchronous memory.
// The result strobe rsp_valid is registered from the execute state, which the accepting edge enters.
// A new request is accepted only when idle, after the read-modify-write of the count memory is done.
// busy is high for the one cycle in which the memory is updated.
// Reset clears all counts at once through per-slot in-use flags; no clearing pass.
// The receiver cannot stall: rsp_valid marks each word for exactly one cycle.
`include "refcounted_slot_pool_unit_macros.svh"

module refcounted_slot_pool_unit
   import rspu_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SLOT_W-1:0]   req_slot_index,
   // response channel
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_granted_slot,
   output logic [PREV_W-1:0]   rsp_previous_count,
   // configuration
   input  logic                csr_write_enable,
   input  logic [POOL_W-1:0]   csr_write_data
);

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0]            state_ff, state_in;
   logic [POOL_W-1:0]     pool_size_ff;
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;

   logic [KIND_W-1:0]     kind_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic                  in_range_ff;
   search_result_type     search_ff;
   search_result_type     search;

   logic                  accept;
   logic [ADDR_W+SLOT_W-1:0] idx_ext, free_ext;
   logic [ADDR_W-1:0]     idx_addr, free_addr, rd_addr;
   logic                  in_range;

   logic [COUNT_BITS-1:0] rd_data, count;
   logic                  wr_en;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS+PREV_W-1:0] count_ext;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]     granted_ff, granted_in;
   logic [PREV_W-1:0]     prev_ff, prev_in;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff == S_EXEC);

   // free-slot search over the in-use flags
   rspu_free_search #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_search (
      .in_use    (in_use_ff),
      .pool_size (pool_size_ff),
      .result    (search)
   );

   // memory addresses from the 4-bit slot fields
   assign idx_ext   = {{ADDR_W{1'b0}}, req_slot_index};
   assign free_ext  = {{ADDR_W{1'b0}}, search.slot};
   assign idx_addr  = idx_ext[ADDR_W-1:0];
   assign free_addr = free_ext[ADDR_W-1:0];
   assign rd_addr   = (req_kind == KIND_ACQUIRE) ? free_addr : idx_addr;
   assign in_range  = (32'(req_slot_index) < 32'(SLOT_COUNT));

   rspu_count_ram #(
      .DEPTH  (SLOT_COUNT),
      .WIDTH  (COUNT_BITS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a slot not in use reads as zero, which covers counts never written
   assign count     = in_use_ff[addr_ff] ? rd_data : '0;
   assign count_ext = {{PREV_W{1'b0}}, count};

   // state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // update of the addressed count and the response word
   always_comb begin
      wr_en      = 1'b0;
      wr_data    = count;
      in_use_in  = in_use_ff;
      status_in  = STATUS_NOT_FOUND;
      granted_in = '0;
      prev_in    = '0;
      if (state_ff == S_EXEC) begin
         unique case (kind_ff)
            KIND_ACQUIRE: begin
               if (search_ff.found) begin
                  wr_en              = 1'b1;
                  wr_data            = COUNT_BITS'(1);
                  in_use_in[addr_ff] = 1'b1;
                  status_in          = STATUS_OK;
                  granted_in         = search_ff.slot;
               end
            end
            KIND_ADD: begin
               if (in_range_ff) begin
                  prev_in = count_ext[PREV_W-1:0];
                  if (&count) begin
                     status_in = STATUS_SATURATED;
                  end else begin
                     wr_en              = 1'b1;
                     wr_data            = count + COUNT_BITS'(1);
                     in_use_in[addr_ff] = 1'b1;
                     status_in          = STATUS_OK;
                  end
               end
            end
            KIND_DROP: begin
               if (in_range_ff && (count != '0)) begin
                  prev_in            = count_ext[PREV_W-1:0];
                  wr_en              = 1'b1;
                  wr_data            = count - COUNT_BITS'(1);
                  in_use_in[addr_ff] = (count != COUNT_BITS'(1));
                  status_in          = STATUS_OK;
               end
            end
            default: begin
               status_in = STATUS_NOT_FOUND;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pool_size_ff <= POOL_RESET;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
         if (csr_write_enable) begin
            pool_size_ff <= csr_write_data;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         addr_ff     <= rd_addr;
         in_range_ff <= in_range;
         search_ff   <= search;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         prev_ff    <= prev_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_slot   = granted_ff;
   assign rsp_previous_count = prev_ff;

   // checks
   `RSPU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RSPU_ASSERT_NEXT(a_exec_responds, clock, reset, busy, rsp_valid && !busy)
   `RSPU_ASSERT_IMPL(a_grant_in_pool, clock, reset, rsp_valid && (rsp_status == STATUS_OK) && (rsp_granted_slot != '0), ({1'b0, rsp_granted_slot} < pool_size_ff) || (kind_ff != KIND_ACQUIRE))

endmodule

// ----- src/rspu_count_ram.sv -----
// Count memory: one write port, one read port with registered read data.
module rspu_count_ram
   import rspu_pkg::*;
#(
   parameter int DEPTH  = DEF_SLOT_COUNT,
   parameter int WIDTH  = DEF_COUNT_BITS,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rspu_free_search.sv -----
// Lowest free slot below the pool size, from the per-slot in-use flags.
module rspu_free_search
   import rspu_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
   input  logic [SLOT_COUNT-1:0] in_use,
   input  logic [POOL_W-1:0]     pool_size,
   output search_result_type     result
);

   localparam int SEARCH_N = (SLOT_COUNT < SEARCH_MAX) ? SLOT_COUNT : SEARCH_MAX;

   // priority encoder, lowest index wins
   always_comb begin
      result.found = 1'b0;
      result.slot  = '0;
      for (int i = SEARCH_N - 1; i >= 0; i--) begin
         if (!in_use[i] && (POOL_W'(i) < pool_size)) begin
            result.found = 1'b1;
            result.slot  = SLOT_W'(i);
         end
      end
   end

endmodule

// ----- tb/tb_refcounted_slot_pool_unit.sv -----
// Self-checking testbench for the reference-counted slot pool unit.
`timescale 1ns / 100ps

module tb_refcounted_slot_pool_unit;
   import rspu_pkg::*;

   localparam int SLOT_TOTAL     = DEF_SLOT_COUNT;
   localparam int RESULT_LATENCY = 2;
   localparam int IDLE_PCT       = 36;
   localparam int REPORT_LIMIT   = 10;
   // no package name for the spare request code
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [DEF_COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
   } pool_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   granted;
      logic [PREV_W-1:0]   prev;
   } pool_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_ACQUIRE;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_granted_slot;
   logic [PREV_W-1:0]   rsp_previous_count;
   logic                csr_write_enable = 1'b0;
   logic [POOL_W-1:0]   csr_write_data = '0;

   // predictor state
   logic [DEF_COUNT_BITS-1:0] slot_refs [SLOT_TOTAL];
   logic [POOL_W-1:0]         pool_limit = POOL_RESET;

   pool_req_type   pending_requests [$];
   pool_reply_type expected_replies [$];
   pool_req_type   next_req;
   pool_reply_type got_reply;
   int          words_queued   = 0;
   int          words_accepted = 0;
   int          drive_count    = 0;
   int          error_count    = 0;
   int          hot_slot       = 0;

   refcounted_slot_pool_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_slot   (rsp_granted_slot),
      .rsp_previous_count (rsp_previous_count),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < SLOT_TOTAL; i++) slot_refs[i] = '0;
   end

   // expected reply for one request; updates the shadow counts
   function automatic pool_reply_type compute_pool_reply(logic [KIND_W-1:0] kind,
                                                         logic [SLOT_W-1:0] idx);
      pool_reply_type r;
      int          limit;
      logic        hit;
      r     = '{status: STATUS_NOT_FOUND, granted: '0, prev: '0};
      limit = pool_limit;
      hit   = 1'b0;
      if (limit > SLOT_TOTAL) limit = SLOT_TOTAL;
      if (limit > SEARCH_MAX) limit = SEARCH_MAX;
      case (kind)
         KIND_ACQUIRE: begin
            // lowest free slot inside the pool
            for (int i = 0; i < limit; i++) begin
               if (!hit && slot_refs[i] == '0) begin
                  hit          = 1'b1;
                  slot_refs[i] = DEF_COUNT_BITS'(1);
                  r.granted    = SLOT_W'(i);
                  r.status     = STATUS_OK;
               end
            end
         end
         KIND_ADD: begin
            if (idx < SLOT_TOTAL) begin
               r.prev = slot_refs[idx];
               if (slot_refs[idx] == COUNT_MAX) begin
                  r.status = STATUS_SATURATED;
               end else begin
                  slot_refs[idx] = slot_refs[idx] + 1'b1;
                  r.status       = STATUS_OK;
               end
            end
         end
         KIND_DROP: begin
            if (idx < SLOT_TOTAL && slot_refs[idx] != '0) begin
               r.prev         = slot_refs[idx];
               slot_refs[idx] = slot_refs[idx] - 1'b1;
               r.status       = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic record_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic queue_word(input logic [KIND_W-1:0] kind, input int slot);
      pending_requests.push_back('{kind: kind, slot: slot[SLOT_W-1:0]});
      words_queued++;
   endtask

   // weighted mix of request kinds; the rest of the hundred is spare-code noise
   task automatic queue_random_words(input int n, input int acq_pct, input int add_pct,
                                     input int drop_pct, input int hot_pct);
      int r;
      int slot;
      for (int i = 0; i < n; i++) begin
         r    = $urandom_range(0, 99);
         slot = ($urandom_range(0, 99) < hot_pct) ? hot_slot : $urandom_range(0, 15);
         if (r < acq_pct)                           queue_word(KIND_ACQUIRE, slot);
         else if (r < acq_pct + add_pct)            queue_word(KIND_ADD, slot);
         else if (r < acq_pct + add_pct + drop_pct) queue_word(KIND_DROP, slot);
         else                                       queue_word(KIND_UNUSED, slot);
      end
   endtask

   // all words accepted and answered, then let the pipeline settle
   task automatic await_quiet();
      while (words_accepted != words_queued || expected_replies.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [POOL_W-1:0] value);
      await_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pool_limit = value;
   endtask

   // request driver: random gaps except for one calm stretch
   always @(posedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         req_kind       <= KIND_ACQUIRE;
         req_slot_index <= '0;
      end else if (!start || !busy) begin
         if (pending_requests.size() > 0 &&
             ((drive_count >= 700 && drive_count < 1000) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_req = pending_requests.pop_front();
            start          <= 1'b1;
            req_kind       <= next_req.kind;
            req_slot_index <= next_req.slot;
            drive_count++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on accept, compare on strobe
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_replies.push_back(compute_pool_reply(req_kind, req_slot_index));
            words_accepted++;
         end
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               record_error($sformatf("unexpected word: status %0d slot %0d prev %0d",
                            rsp_status, rsp_granted_slot, rsp_previous_count));
            end else begin
               got_reply = expected_replies.pop_front();
               if (rsp_status !== got_reply.status)
                  record_error($sformatf("status: expected %0d, got %0d",
                               got_reply.status, rsp_status));
               if (rsp_granted_slot !== got_reply.granted)
                  record_error($sformatf("granted_slot: expected %0d, got %0d",
                               got_reply.granted, rsp_granted_slot));
               if (rsp_previous_count !== got_reply.prev)
                  record_error($sformatf("previous_count: expected %0d, got %0d",
                               got_reply.prev, rsp_previous_count));
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: grants, adds to a held and a free slot, drop at zero, spare code
      queue_word(KIND_ACQUIRE, 0);
      queue_word(KIND_ACQUIRE, 7);
      queue_word(KIND_ADD, 0);
      queue_word(KIND_ADD, 15);
      queue_word(KIND_DROP, 1);
      queue_word(KIND_DROP, 1);
      queue_word(KIND_DROP, 9);
      queue_word(KIND_UNUSED, 15);
      queue_word(KIND_UNUSED, 0);
      queue_word(KIND_ACQUIRE, 15);
      queue_word(KIND_ACQUIRE, 0);
      queue_word(KIND_DROP, 15);

      // empty pool: acquire must miss
      write_pool_size(5'd0);
      queue_word(KIND_ACQUIRE, 0);
      queue_word(KIND_ADD, 4);
      queue_word(KIND_DROP, 4);

      // oversized pool clamps to the slot count
      write_pool_size(5'd31);
      queue_word(KIND_ACQUIRE, 0);
      queue_word(KIND_ACQUIRE, 0);
      queue_word(KIND_ADD, 15);
      queue_random_words(300, 40, 25, 30, 0);

      // single-slot pool runs out quickly
      write_pool_size(5'd1);
      queue_random_words(150, 40, 20, 35, 0);

      // hammer one slot until its count saturates
      write_pool_size(5'd16);
      hot_slot = $urandom_range(0, 15);
      queue_random_words(400, 5, 90, 4, 90);

      // drain mostly the same slot
      write_pool_size(5'd2);
      queue_random_words(300, 10, 5, 82, 80);

      for (int p = 0; p < 3; p++) begin
         write_pool_size(POOL_W'($urandom_range(0, 31)));
         hot_slot = $urandom_range(0, 15);
         queue_random_words(150, 30, 30, 35, 10);
      end

      write_pool_size(5'd16);
      queue_random_words(150, 35, 25, 35, 0);

      await_quiet();
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
